// ===== rtl/frdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frdr_pkg
// Shared widths and constants for the dielectric Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package frdr_pkg;
    localparam int unsigned ETA_W   = 16;
    localparam int unsigned COS_W   = 17;  // cosine magnitude, up to 2^15
    localparam int unsigned RAD_W   = 62;  // radicand width, Q.54 below 2^62
    localparam int unsigned ROOT_W  = 31;  // square root width
    localparam int unsigned SQ_STG  = 31;  // one root bit per stage
    localparam int unsigned DIV_W   = 49;  // ratio numerator and denominator
    localparam int unsigned QUO_W   = 30;  // Q0.30 quotient
    localparam int unsigned DIV_STG = 30;  // one quotient bit per stage
    localparam int unsigned RAT_W   = 31;  // ratio including 1.0

    localparam logic [ETA_W-1:0] ETA_ONE = 16'd4096;
    localparam logic [15:0]      REFL_ONE = 16'd32768;

    typedef enum logic [0:0] {
        t_REG_ETA_I = 1'b0,
        t_REG_ETA_T = 1'b1
    } t_reg_idx;
endpackage

// ===== rtl/fresnel_dielectric_reflectance_unit.sv =====
`timescale 1ns / 1ps
// The 31-stage root and 30-stage divider set the pipeline depth.
// Throughput: one word per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline, nothing is lost or repeated.
// Reset (synchronous, active low) clears valid bits and sets both indices to 1.0.
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_unit
// Unpolarized Fresnel reflectance of a dielectric interface, fully pipelined.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_cos_theta,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_reflectance,
    output logic               o_total_reflection
);
    localparam int unsigned SQ  = frdr_pkg::SQ_STG;
    localparam int unsigned DV  = frdr_pkg::DIV_STG;
    localparam int unsigned LAT = 4 + SQ + 2 + DV + 2;

    logic [15:0]     r_eta_i, r_eta_t;
    logic [LAT-1:0]  r_vld;
    logic            en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_i <= frdr_pkg::ETA_ONE;
            r_eta_t <= frdr_pkg::ETA_ONE;
        end else if (i_cfg_we) begin
            unique case (frdr_pkg::t_reg_idx'(i_cfg_index))
                frdr_pkg::t_REG_ETA_I: r_eta_i <= i_cfg_data;
                frdr_pkg::t_REG_ETA_T: r_eta_t <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance whenever the output word is not held
    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // stage A: magnitude and swap
    logic [16:0] raw_mag;
    logic        swap;
    logic [16:0] r_a_c;
    logic [15:0] r_a_ei, r_a_et;
    assign raw_mag = i_cos_theta[15] ? (17'd65536 - {1'b0, i_cos_theta})
                                     : {1'b0, i_cos_theta};
    assign swap    = i_cos_theta[15] || (i_cos_theta == 16'sd0);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_c  <= raw_mag;
            r_a_ei <= swap ? r_eta_t : r_eta_i;
            r_a_et <= swap ? r_eta_i : r_eta_t;
        end
    end

    // stage B: squares
    logic [30:0] r_b_cc;
    logic [31:0] r_b_ei2, r_b_et2;
    logic [16:0] r_b_c;
    logic [15:0] r_b_ei;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_cc  <= 31'(r_a_c * r_a_c);
            r_b_ei2 <= r_a_ei * r_a_ei;
            r_b_et2 <= r_a_et * r_a_et;
            r_b_c   <= r_a_c;
            r_b_ei  <= r_a_ei;
        end
    end

    // stage C: ei^2 * sin^2
    logic [30:0] s2;
    logic [62:0] r_c_lhs;
    logic [31:0] r_c_et2;
    logic [16:0] r_c_c;
    logic [15:0] r_c_ei;
    assign s2 = 31'h4000_0000 - r_b_cc;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_lhs <= 63'(r_b_ei2) * 63'(s2);
            r_c_et2 <= r_b_et2;
            r_c_c   <= r_b_c;
            r_c_ei  <= r_b_ei;
        end
    end

    // stage D: total reflection test and radicand
    logic [62:0] rhs;
    logic        r_d_tir;
    logic [frdr_pkg::RAD_W-1:0] r_d_rad;
    logic [31:0] r_d_et2;
    logic [16:0] r_d_c;
    logic [15:0] r_d_ei;
    assign rhs = {1'b0, r_c_et2, 30'd0};
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_tir <= (r_c_lhs >= rhs);
            r_d_rad <= frdr_pkg::RAD_W'(rhs - r_c_lhs);
            r_d_et2 <= r_c_et2;
            r_d_c   <= r_c_c;
            r_d_ei  <= r_c_ei;
        end
    end

    // square root, side data follows in a delay line
    logic [frdr_pkg::ROOT_W-1:0] q;
    frdr_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_d_rad),
        .o_root (q)
    );

    logic        r_sq_tir [SQ];
    logic [31:0] r_sq_et2 [SQ];
    logic [16:0] r_sq_c   [SQ];
    logic [15:0] r_sq_ei  [SQ];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_tir[0] <= r_d_tir;
            r_sq_et2[0] <= r_d_et2;
            r_sq_c[0]   <= r_d_c;
            r_sq_ei[0]  <= r_d_ei;
            for (int k = 1; k < SQ; k++) begin
                r_sq_tir[k] <= r_sq_tir[k-1];
                r_sq_et2[k] <= r_sq_et2[k-1];
                r_sq_c[k]   <= r_sq_c[k-1];
                r_sq_ei[k]  <= r_sq_ei[k-1];
            end
        end
    end

    // stage E: ratio terms
    logic [frdr_pkg::DIV_W-1:0] r_e_a1, r_e_b1, r_e_a2, r_e_b2;
    logic                       r_e_tir;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_a1  <= frdr_pkg::DIV_W'(r_sq_et2[SQ-1] * r_sq_c[SQ-1]);
            r_e_b1  <= frdr_pkg::DIV_W'(r_sq_ei[SQ-1] * q);
            r_e_a2  <= frdr_pkg::DIV_W'(r_sq_ei[SQ-1] * r_sq_c[SQ-1]);
            r_e_b2  <= frdr_pkg::DIV_W'(q);
            r_e_tir <= r_sq_tir[SQ-1];
        end
    end

    // stage F: numerators, denominators, full-ratio flags
    logic [frdr_pkg::DIV_W-1:0] num1, den1, num2, den2;
    logic [frdr_pkg::DIV_W-1:0] r_f_num1, r_f_den1, r_f_num2, r_f_den2;
    logic                       r_f_one1, r_f_one2, r_f_tir;
    assign num1 = (r_e_a1 > r_e_b1) ? r_e_a1 - r_e_b1 : r_e_b1 - r_e_a1;
    assign den1 = r_e_a1 + r_e_b1;
    assign num2 = (r_e_a2 > r_e_b2) ? r_e_a2 - r_e_b2 : r_e_b2 - r_e_a2;
    assign den2 = r_e_a2 + r_e_b2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_num1 <= num1;
            r_f_den1 <= den1;
            r_f_one1 <= (den1 == '0) || (num1 >= den1);
            r_f_num2 <= num2;
            r_f_den2 <= den2;
            r_f_one2 <= (den2 == '0) || (num2 >= den2);
            r_f_tir  <= r_e_tir;
        end
    end

    // dividers
    logic [frdr_pkg::RAT_W-1:0] rat1, rat2;
    frdr_div u_div_par (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (r_f_num1),
        .i_den   (r_f_den1),
        .i_one   (r_f_one1),
        .o_ratio (rat1)
    );
    frdr_div u_div_perp (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (r_f_num2),
        .i_den   (r_f_den2),
        .i_one   (r_f_one2),
        .o_ratio (rat2)
    );

    logic r_dv_tir [DV];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_tir[0] <= r_f_tir;
            for (int k = 1; k < DV; k++) begin
                r_dv_tir[k] <= r_dv_tir[k-1];
            end
        end
    end

    // stage G: squared ratios
    logic [61:0] r_g_sq1, r_g_sq2;
    logic        r_g_tir;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_sq1 <= 62'(rat1) * 62'(rat1);
            r_g_sq2 <= 62'(rat2) * 62'(rat2);
            r_g_tir <= r_dv_tir[DV-1];
        end
    end

    // stage H: average, round, saturate into the output word
    logic [62:0] sum;
    logic [16:0] refl;
    logic [15:0] r_h_refl;
    logic        r_h_tir;
    assign sum  = 63'(r_g_sq1) + 63'(r_g_sq2) + (63'(1) << 45);
    assign refl = sum[62:46];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_tir <= r_g_tir;
            if (r_g_tir || refl > 17'(frdr_pkg::REFL_ONE)) begin
                r_h_refl <= frdr_pkg::REFL_ONE;
            end else begin
                r_h_refl <= refl[15:0];
            end
        end
    end

    assign o_valid            = r_vld[LAT-1];
    assign o_reflectance      = r_h_refl;
    assign o_total_reflection = r_h_tir;
endmodule

// ===== rtl/frdr_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frdr_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module frdr_sqrt (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [frdr_pkg::RAD_W-1:0]        i_x,
    output logic [frdr_pkg::ROOT_W-1:0]       o_root
);
    logic [frdr_pkg::RAD_W-1:0] r_x   [frdr_pkg::SQ_STG];
    logic [frdr_pkg::RAD_W-1:0] r_res [frdr_pkg::SQ_STG];

    for (genvar k = 0; k < frdr_pkg::SQ_STG; k++) begin : g_stg
        localparam logic [frdr_pkg::RAD_W-1:0] BIT =
            frdr_pkg::RAD_W'(1) << (2 * (frdr_pkg::SQ_STG - 1 - k));
        logic [frdr_pkg::RAD_W-1:0] x_in, res_in, trial;
        if (k == 0) begin : g_first
            assign x_in   = i_x;
            assign res_in = '0;
        end else begin : g_rest
            assign x_in   = r_x[k-1];
            assign res_in = r_res[k-1];
        end
        assign trial = res_in + BIT;
        // try one root bit, keep the remainder
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (x_in >= trial) begin
                    r_x[k]   <= x_in - trial;
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_x[k]   <= x_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign o_root = r_res[frdr_pkg::SQ_STG-1][frdr_pkg::ROOT_W-1:0];
endmodule

// ===== rtl/frdr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frdr_div
// Pipelined restoring divider giving num/den in Q0.30, one bit per stage.
// ----------------------------------------------------------------------------
module frdr_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [frdr_pkg::DIV_W-1:0]        i_num,
    input  logic [frdr_pkg::DIV_W-1:0]        i_den,
    input  logic                              i_one,
    output logic [frdr_pkg::RAT_W-1:0]        o_ratio
);
    localparam int unsigned REM_W = frdr_pkg::DIV_W + 1;

    logic [REM_W-1:0]               r_rem [frdr_pkg::DIV_STG];
    logic [frdr_pkg::DIV_W-1:0]     r_den [frdr_pkg::DIV_STG];
    logic [frdr_pkg::QUO_W-1:0]     r_quo [frdr_pkg::DIV_STG];
    logic                           r_one [frdr_pkg::DIV_STG];

    for (genvar k = 0; k < frdr_pkg::DIV_STG; k++) begin : g_stg
        logic [REM_W-1:0]           rem_in, rem_sh;
        logic [frdr_pkg::DIV_W-1:0] den_in;
        logic [frdr_pkg::QUO_W-1:0] quo_in;
        logic                       one_in;
        if (k == 0) begin : g_first
            assign rem_in = REM_W'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
            assign one_in = i_one;
        end else begin : g_rest
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
            assign one_in = r_one[k-1];
        end
        assign rem_sh = rem_in << 1;
        // shift in one quotient bit
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= den_in;
                r_one[k] <= one_in;
                if (rem_sh >= REM_W'(den_in)) begin
                    r_rem[k] <= rem_sh - REM_W'(den_in);
                    r_quo[k] <= {quo_in[frdr_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= rem_sh;
                    r_quo[k] <= {quo_in[frdr_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_ratio = r_one[frdr_pkg::DIV_STG-1]
                   ? (frdr_pkg::RAT_W'(1) << frdr_pkg::QUO_W)
                   : frdr_pkg::RAT_W'(r_quo[frdr_pkg::DIV_STG-1]);
endmodule

// ===== rtl/frdr_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frdr_chk
// Port-level checks for the Fresnel reflectance unit, bound to the top level.
// ----------------------------------------------------------------------------
module frdr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_reflectance,
    input logic        o_total_reflection
);
    // hold the output word while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_reflectance)
                               && $stable(o_total_reflection))
        else $error("output word changed under stall");

    // total reflection reports full reflectance
    a_tir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_total_reflection |-> o_reflectance == 16'd32768)
        else $error("total reflection without full reflectance");

    // reflectance never exceeds 1.0
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_reflectance <= 16'd32768)
        else $error("reflectance above 1.0");

    // input stall only comes from a held output
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");
endmodule

bind fresnel_dielectric_reflectance_unit frdr_chk u_frdr_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_reflectance      (o_reflectance),
    .o_total_reflection (o_total_reflection)
);
